// File: rtl/pq_pkg.sv
// ----------------------------------------------------------------------------
// pq_pkg: shared types and constants of the palette quantizer
// Color layout, distance width, result kinds, sequencer states and the
// control bundle that drives the distance unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pq_pkg;

  localparam int COLOR_W   = 24;
  localparam int CHAN_W    = 8;
  localparam int RED_LSB   = 16;
  localparam int GREEN_LSB = 8;
  localparam int BLUE_LSB  = 0;
  localparam int SQ_W      = 2 * CHAN_W;
  localparam int DIST_W    = SQ_W + 2;
  localparam int INDEX_W   = 8;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_EXACT    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPENDED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEAREST  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } pq_state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } pq_ctrl_t;

endpackage : pq_pkg

`default_nettype wire

// File: rtl/pq_ram.sv
// ----------------------------------------------------------------------------
// pq_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : pq_ram

`default_nettype wire

// File: rtl/pq_dist.sv
// ----------------------------------------------------------------------------
// pq_dist: squared RGB distance and running minimum
// Stage one registers the three channel squares, stage two sums them and
// keeps the least distance seen since the last clear, ties to the first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pq_dist
  import pq_pkg::*;
#(
  parameter int IDX_W = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pq_ctrl_t            ctrl,
  input  wire logic [COLOR_W-1:0]  color,
  input  wire logic [COLOR_W-1:0]  entry,
  input  wire logic [IDX_W-1:0]    idx,
  output logic                     busy,
  output logic      [DIST_W-1:0]   best_dist,
  output logic      [IDX_W-1:0]    best_idx
);

  logic [CHAN_W-1:0] diff_r, diff_g, diff_b;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic              sq_valid;
  logic [IDX_W-1:0]  sq_idx;
  logic [DIST_W-1:0] sum_dist;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    diff_r   = abs_diff(color[RED_LSB +: CHAN_W],   entry[RED_LSB +: CHAN_W]);
    diff_g   = abs_diff(color[GREEN_LSB +: CHAN_W], entry[GREEN_LSB +: CHAN_W]);
    diff_b   = abs_diff(color[BLUE_LSB +: CHAN_W],  entry[BLUE_LSB +: CHAN_W]);
    sum_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= ctrl.valid;
    end
    sq_r   <= SQ_W'(diff_r) * SQ_W'(diff_r);
    sq_g   <= SQ_W'(diff_g) * SQ_W'(diff_g);
    sq_b   <= SQ_W'(diff_b) * SQ_W'(diff_b);
    sq_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      best_dist <= '1;
      best_idx  <= '0;
    end else if (sq_valid && (sum_dist < best_dist)) begin
      best_dist <= sum_dist;
      best_idx  <= sq_idx;
    end
  end

  assign busy = sq_valid;

endmodule : pq_dist

`default_nettype wire

// File: rtl/palette_quantizer_append_or_nearest.sv
// ----------------------------------------------------------------------------
// palette_quantizer_append_or_nearest: on-the-fly palette color quantizer
// Maps each RGB color to an index of a palette built from the colors seen.
// ----------------------------------------------------------------------------
// A transaction is taken at the edge where start is high and busy is low.
// The block scans the N valid palette entries, one per cycle from the palette
// RAM port, through a two-stage distance pipeline. The result is shown on
// palette_index and match_kind for exactly one cycle with done high and must
// be captured then; the block never waits on the receiver. Exact matches
// return the first equal entry, unmatched colors are appended while slots
// remain, and a full palette returns the nearest entry by squared RGB
// distance, ties to the lowest index. restart empties the palette before the
// color is handled. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_quantizer_append_or_nearest
  import pq_pkg::*;
#(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [COLOR_W-1:0] pixel_color,
  input  wire logic               restart,
  output logic                    done,
  output logic      [INDEX_W-1:0] palette_index,
  output logic      [KIND_W-1:0]  match_kind
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

  pq_state_t         state, state_next;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_addr_inc;
  logic [COLOR_W-1:0] color;
  logic              rd_valid;
  logic [IDX_W-1:0]  rd_idx;
  logic [COLOR_W-1:0] rd_data;
  logic              accept;
  logic              we;
  logic              pipe_busy;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  pq_ctrl_t          ctrl;

  assign accept      = start && (state == S_IDLE);
  assign busy        = (state != S_IDLE);
  assign rd_addr_inc = rd_addr + CNT_W'(1);
  assign ctrl.clear  = accept;
  assign ctrl.valid  = rd_valid;
  assign we          = (state == S_FINISH) && (best_dist != '0) &&
                       (entry_count < DEPTH_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (restart || (entry_count == '0)) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_addr_inc == entry_count) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid && !pipe_busy) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      rd_valid    <= 1'b0;
      done        <= 1'b0;
    end else begin
      rd_valid <= (state == S_SCAN);
      done     <= (state == S_FINISH);
      if (accept && restart) begin
        entry_count <= '0;
      end else if (we) begin
        entry_count <= entry_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      color   <= pixel_color;
      rd_addr <= '0;
    end else if (state == S_SCAN) begin
      rd_addr <= rd_addr_inc;
    end
    rd_idx <= rd_addr[IDX_W-1:0];
    if (state == S_FINISH) begin
      if (best_dist == '0) begin
        palette_index <= INDEX_W'(best_idx);
        match_kind    <= KIND_EXACT;
      end else if (entry_count < DEPTH_CNT) begin
        palette_index <= INDEX_W'(entry_count[IDX_W-1:0]);
        match_kind    <= KIND_APPENDED;
      end else begin
        palette_index <= INDEX_W'(best_idx);
        match_kind    <= KIND_NEAREST;
      end
    end
  end

  pq_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (we),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (color),
    .raddr (rd_addr[IDX_W-1:0]),
    .rdata (rd_data)
  );

  pq_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .color     (color),
    .entry     (rd_data),
    .idx       (rd_idx),
    .busy      (pipe_busy),
    .best_dist (best_dist),
    .best_idx  (best_idx)
  );

endmodule : palette_quantizer_append_or_nearest

`default_nettype wire

// File: sim/palette_quantizer_append_or_nearest_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_quantizer_append_or_nearest_tb: palette quantizer regression
// Sends RGB colors through the start/busy handshake in bursts with random
// gaps. A shadow palette predicts the index and kind of every lookup:
// exact hits, appends, restarts, and nearest-color search with ties on a
// full palette. The test checks each done strobe against the oldest
// prediction.
// ----------------------------------------------------------------------------
module palette_quantizer_append_or_nearest_tb;
  import pq_pkg::*;

  localparam int DEPTH        = 256;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [KIND_W-1:0]  kind;
  } lookup_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [COLOR_W-1:0] pixel_color = '0;
  logic               restart = 1'b0;
  logic               done;
  logic [INDEX_W-1:0] palette_index;
  logic [KIND_W-1:0]  match_kind;

  logic [COLOR_W-1:0] shadow_palette [DEPTH];
  int                 shadow_count = 0;
  lookup_t            expected_lookups [$];

  int error_count   = 0;
  int sent_count    = 0;
  int restart_count = 0;
  int kind_seen [3] = '{0, 0, 0};
  int quiet_cycles  = 0;
  int burst_left    = 0;

  always #10 clk = ~clk;

  palette_quantizer_append_or_nearest #(
    .PALETTE_DEPTH(DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_color  (pixel_color),
    .restart      (restart),
    .done         (done),
    .palette_index(palette_index),
    .match_kind   (match_kind)
  );

  function automatic int color_dist(input logic [COLOR_W-1:0] a,
                                    input logic [COLOR_W-1:0] b);
    int dr;
    int dg;
    int db;
    dr = int'(a[RED_LSB +: CHAN_W]) - int'(b[RED_LSB +: CHAN_W]);
    dg = int'(a[GREEN_LSB +: CHAN_W]) - int'(b[GREEN_LSB +: CHAN_W]);
    db = int'(a[BLUE_LSB +: CHAN_W]) - int'(b[BLUE_LSB +: CHAN_W]);
    return dr * dr + dg * dg + db * db;
  endfunction

  task automatic predict_lookup(input logic [COLOR_W-1:0] color, input logic clear);
    lookup_t res;
    int      best_d;
    int      d;
    int      i;
    bit      hit;
    hit = 1'b0;
    res.index = '0;
    res.kind = KIND_NEAREST;
    if (clear) begin
      shadow_count = 0;
    end
    for (i = 0; i < shadow_count && !hit; i++) begin
      if (shadow_palette[i] == color) begin
        res.index = INDEX_W'(i);
        res.kind = KIND_EXACT;
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (shadow_count < DEPTH) begin
        shadow_palette[shadow_count] = color;
        res.index = INDEX_W'(shadow_count);
        res.kind = KIND_APPENDED;
        shadow_count++;
      end else begin
        best_d = 32'h7fffffff;
        for (i = 0; i < shadow_count; i++) begin
          d = color_dist(color, shadow_palette[i]);
          if (d < best_d) begin
            best_d = d;
            res.index = INDEX_W'(i);
          end
        end
      end
    end
    expected_lookups.push_back(res);
  endtask

  // Hold start between transactions of a burst; drop it for the gap after one.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(40, 1);
      if ($urandom_range(3, 0) == 0) begin
        gap = 0;
      end else if ($urandom_range(7, 0) == 0) begin
        gap = $urandom_range(280, 1);
      end else begin
        gap = $urandom_range(12, 1);
      end
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic send_color(input logic [COLOR_W-1:0] color, input logic clear);
    @(negedge clk);
    start <= 1'b1;
    pixel_color <= color;
    restart <= clear;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_lookup(color, clear);
    sent_count++;
    if (clear) begin
      restart_count++;
    end
    pace();
  endtask

  task automatic test_directed();
    send_color(24'h000000, 1'b1);
    send_color(24'h000000, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'hFF0000, 1'b0);
    send_color(24'h00FF00, 1'b0);
    send_color(24'h0000FF, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'hFF0000, 1'b0);
    send_color(24'hAAAAAA, 1'b0);
    send_color(24'h555555, 1'b0);
    send_color(24'h555555, 1'b0);
    send_color(24'hFFFFFF, 1'b1);
    send_color(24'h000000, 1'b0);
    send_color(24'hFFFFFF, 1'b1);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'h000000, 1'b0);
  endtask

  task automatic test_full_palette();
    int k;
    for (k = 0; k < DEPTH; k++) begin
      if (k < DEPTH / 2) begin
        send_color({8'(2 * k), 8'h00, 8'h00}, k == 0);
      end else begin
        send_color({8'h00, 8'hFF, 8'(2 * (k - DEPTH / 2))}, 1'b0);
      end
    end
    send_color(24'h000000, 1'b0);
    send_color({8'd254, 8'h00, 8'h00}, 1'b0);
    send_color(24'h00FF00, 1'b0);
    send_color(24'h00FFFE, 1'b0);
    send_color(24'h010000, 1'b0);
    send_color({8'd201, 8'h00, 8'h00}, 1'b0);
    send_color(24'h00FF03, 1'b0);
    send_color(24'hFF0000, 1'b0);
    send_color(24'h808080, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'h00FFFF, 1'b0);
    send_color(24'h0000FF, 1'b0);
    send_color(24'h123456, 1'b1);
    send_color(24'h123456, 1'b0);
  endtask

  task automatic test_random_small();
    logic [COLOR_W-1:0] pool [32];
    int                 pool_size;
    int                 len;
    int                 n;
    int                 j;
    logic [COLOR_W-1:0] color;
    repeat (40) begin
      pool_size = $urandom_range(32, 1);
      for (j = 0; j < pool_size; j++) begin
        pool[j] = COLOR_W'($urandom());
      end
      len = $urandom_range(30, 1);
      for (n = 0; n < len; n++) begin
        if ($urandom_range(3, 0) == 0) begin
          color = COLOR_W'($urandom());
        end else begin
          color = pool[$urandom_range(pool_size - 1, 0)];
        end
        send_color(color, (n == 0) || ($urandom_range(15, 0) == 0));
      end
    end
  endtask

  task automatic test_random_full();
    logic [COLOR_W-1:0] color;
    logic [COLOR_W-1:0] jitter;
    bit                 first;
    int                 sel;
    repeat (2) begin
      first = 1'b1;
      while (first || shadow_count < DEPTH) begin
        if (!first && $urandom_range(9, 0) == 0) begin
          color = shadow_palette[$urandom_range(shadow_count - 1, 0)];
        end else begin
          color = COLOR_W'($urandom());
        end
        send_color(color, first);
        first = 1'b0;
      end
      repeat (200) begin
        sel = $urandom_range(3, 0);
        color = shadow_palette[$urandom_range(DEPTH - 1, 0)];
        jitter = COLOR_W'($urandom()) & 24'h0F0F0F;
        if (sel == 0) begin
          color = COLOR_W'($urandom());
        end else if (sel != 1) begin
          color = color ^ jitter;
        end
        send_color(color, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    lookup_t want;
    if (!rst) begin
      if ((start && !busy) || done) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (done) begin
        if (match_kind <= KIND_NEAREST) begin
          kind_seen[match_kind]++;
        end
        if (expected_lookups.size() == 0) begin
          $error("unexpected result: palette_index %0d, match_kind %0d",
                 palette_index, match_kind);
          error_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (palette_index !== want.index) begin
            $error("palette_index: expected %0d, got %0d", want.index, palette_index);
            error_count++;
          end
          if (match_kind !== want.kind) begin
            $error("match_kind: expected %0d, got %0d", want.kind, match_kind);
            error_count++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_palette();
    test_random_small();
    test_random_full();
    @(negedge clk);
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d colors, %0d with restart, on small and full palettes.",
             sent_count, restart_count);
    $display("Results seen: %0d exact, %0d appended, %0d nearest.",
             kind_seen[KIND_EXACT], kind_seen[KIND_APPENDED], kind_seen[KIND_NEAREST]);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
